[rtl/clm_pkg.sv]
`default_nettype none
package clm_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int NAME_CMP    = 15;
    localparam int CFG_IDX_W   = 3;

    localparam logic OP_ENTER = 1'b0;
    localparam logic OP_EXIT  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MASK_0   = 3'd0,
        REG_MASK_1   = 3'd1,
        REG_MASK_2   = 3'd2,
        REG_MASK_3   = 3'd3,
        REG_NAME_LOW = 3'd4,
        REG_NAME_HI  = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_ACT
    } t_state;

    typedef struct packed {
        logic               opcode;
        logic [31:0]        thread_id;
        logic [7:0]         call_id;
        logic [63:0]        timestamp_ns;
        logic [31:0]        process_id;
        logic signed [63:0] return_value;
        logic [63:0]        name_low;
        logic [63:0]        name_high;
    } t_evt;

    typedef struct packed {
        logic        vld;
        logic [31:0] thread;
        logic [63:0] start;
        logic [7:0]  call;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage
`default_nettype wire

[rtl/clm_if.sv]
`default_nettype none
interface clm_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [31:0]        thread_id;
    logic [7:0]         call_id;
    logic [63:0]        timestamp_ns;
    logic [31:0]        process_id;
    logic signed [63:0] return_value;
    logic [63:0]        name_low;
    logic [63:0]        name_high;

    modport source (output valid, opcode, thread_id, call_id, timestamp_ns, process_id,
                    return_value, name_low, name_high, input ready);
    modport sink   (input valid, opcode, thread_id, call_id, timestamp_ns, process_id,
                    return_value, name_low, name_high, output ready);
endinterface

interface clm_out_if;
    logic               valid;
    logic               ready;
    logic [63:0]        call_latency;
    logic [7:0]         out_call_id;
    logic [31:0]        out_process_id;
    logic [31:0]        out_thread_id;
    logic signed [63:0] out_return_value;
    logic [63:0]        out_name_low;
    logic [63:0]        out_name_high;

    modport source (output valid, call_latency, out_call_id, out_process_id, out_thread_id,
                    out_return_value, out_name_low, out_name_high, input ready);
    modport sink   (input valid, call_latency, out_call_id, out_process_id, out_thread_id,
                    out_return_value, out_name_low, out_name_high, output ready);
endinterface
`default_nettype wire

[rtl/clm_ram.sv]
`default_nettype none
module clm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_we,
    input  wire logic [AW-1:0]           i_waddr,
    input  wire logic [WIDTH-1:0]        i_wdata,
    input  wire logic [AW-1:0]           i_raddr,
    output logic      [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/clm_front.sv]
`default_nettype none
module clm_front
    import clm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    clm_in_if.sink                    i_in,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [63:0]          i_cfg_data,
    output logic                      o_push,
    output t_evt                      o_evt,
    input  wire logic                 i_q_ready
);
    logic [255:0] r_mask;
    logic [63:0]  r_tname_lo;
    logic [55:0]  r_tname_hi;
    logic [119:0] tname;
    logic [127:0] cname;
    logic         cid_en;
    logic         name_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask     <= '0;
            r_tname_lo <= '0;
            r_tname_hi <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MASK_0:   r_mask[63:0]    <= i_cfg_data;
                REG_MASK_1:   r_mask[127:64]  <= i_cfg_data;
                REG_MASK_2:   r_mask[191:128] <= i_cfg_data;
                REG_MASK_3:   r_mask[255:192] <= i_cfg_data;
                REG_NAME_LOW: r_tname_lo      <= i_cfg_data;
                REG_NAME_HI:  r_tname_hi      <= i_cfg_data[55:0];
                default: ;
            endcase
        end
    end

    assign tname  = {r_tname_hi, r_tname_lo};
    assign cname  = {i_in.name_high, i_in.name_low};
    assign cid_en = r_mask[i_in.call_id];

    // stop at the first shared NUL; any mismatch before it fails
    always_comb begin
        logic stop;
        stop    = (tname[7:0] == 8'd0);
        name_ok = 1'b1;
        for (int i = 0; i < NAME_CMP; i++) begin
            if (!stop) begin
                if (tname[8*i +: 8] != cname[8*i +: 8]) begin
                    name_ok = 1'b0;
                    stop    = 1'b1;
                end else if (tname[8*i +: 8] == 8'd0) begin
                    stop = 1'b1;
                end
            end
        end
    end

    assign o_evt.opcode       = i_in.opcode;
    assign o_evt.thread_id    = i_in.thread_id;
    assign o_evt.call_id      = i_in.call_id;
    assign o_evt.timestamp_ns = i_in.timestamp_ns;
    assign o_evt.process_id   = i_in.process_id;
    assign o_evt.return_value = i_in.return_value;
    assign o_evt.name_low     = i_in.name_low;
    assign o_evt.name_high    = i_in.name_high;

    assign i_in.ready = i_q_ready;
    // drop filtered enters here, they never reach the table
    assign o_push = i_in.valid && i_q_ready &&
                    ((i_in.opcode == OP_EXIT) || (cid_en && name_ok));
endmodule
`default_nettype wire

[rtl/clm_queue.sv]
`default_nettype none
module clm_queue
    import clm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_evt i_evt,
    output logic      o_ready,
    output logic      o_valid,
    output t_evt      o_evt,
    input  wire logic i_pop
);
    t_evt       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_evt   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule
`default_nettype wire

[rtl/clm_back.sv]
`default_nettype none
module clm_back
    import clm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    input  wire t_evt i_evt,
    output logic      o_pop,
    clm_out_if.source o_out
);
    t_state             r_state, n_state;
    t_evt               r_evt;
    logic [CNT_W-1:0]   r_addr, n_addr;
    logic               r_chk, n_chk;
    logic [ADDR_W-1:0]  r_chk_idx, n_chk_idx;
    logic               r_hit, n_hit;
    logic [ADDR_W-1:0]  r_slot, n_slot;
    t_entry             r_ent;
    logic               r_free_ok, n_free_ok;
    logic [ADDR_W-1:0]  r_free, n_free;
    logic               r_ov;

    t_entry             rd;
    logic [ENTRY_W-1:0] rd_raw;
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    t_entry             wdata;
    logic [ADDR_W-1:0]  raddr;
    logic               hit_now;
    logic               scan_end;
    logic               out_block;
    logic               out_load;
    logic               last_clear;

    clm_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_raw)
    );

    assign rd         = t_entry'(rd_raw);
    assign raddr      = r_addr[ADDR_W-1:0];
    assign hit_now    = (r_state == S_SCAN) && r_chk && rd.vld &&
                        (rd.thread == r_evt.thread_id);
    assign scan_end   = !r_chk && (r_addr == CNT_W'(TABLE_DEPTH));
    assign last_clear = (r_addr == CNT_W'(TABLE_DEPTH - 1));
    assign out_block  = (r_evt.opcode == OP_EXIT) && r_hit && r_ov && !o_out.ready;
    assign out_load   = (r_state == S_ACT) && (r_evt.opcode == OP_EXIT) && r_hit &&
                        !out_block;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (last_clear) n_state = S_IDLE;
            S_IDLE:  if (i_q_valid) n_state = S_SCAN;
            S_SCAN:  if (hit_now || scan_end) n_state = S_ACT;
            S_ACT:   if (!out_block) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        we        = 1'b0;
        waddr     = r_slot;
        wdata     = '0;
        n_addr    = r_addr;
        n_chk     = 1'b0;
        n_chk_idx = r_chk_idx;
        n_hit     = r_hit;
        n_slot    = r_slot;
        n_free_ok = r_free_ok;
        n_free    = r_free;
        unique case (r_state)
            S_CLEAR: begin
                we     = 1'b1;
                waddr  = r_addr[ADDR_W-1:0];
                n_addr = last_clear ? '0 : r_addr + 1'b1;
            end
            S_IDLE: begin
                o_pop     = i_q_valid;
                n_addr    = '0;
                n_hit     = 1'b0;
                n_free_ok = 1'b0;
            end
            S_SCAN: begin
                if (r_addr != CNT_W'(TABLE_DEPTH)) begin
                    n_chk     = !hit_now;
                    n_chk_idx = r_addr[ADDR_W-1:0];
                    n_addr    = r_addr + 1'b1;
                end
                if (hit_now) begin
                    n_hit  = 1'b1;
                    n_slot = r_chk_idx;
                end
                if (r_chk && !rd.vld && !r_free_ok) begin
                    n_free_ok = 1'b1;
                    n_free    = r_chk_idx;
                end
            end
            S_ACT: begin
                if (r_evt.opcode == OP_EXIT) begin
                    // free the matched entry
                    we = r_hit && !out_block;
                end else begin
                    we           = r_hit || r_free_ok;
                    waddr        = r_hit ? r_slot : r_free;
                    wdata.vld    = 1'b1;
                    wdata.thread = r_evt.thread_id;
                    wdata.start  = r_evt.timestamp_ns;
                    wdata.call   = r_evt.call_id;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_addr    <= '0;
            r_chk     <= 1'b0;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_chk     <= n_chk;
            r_hit     <= n_hit;
            r_free_ok <= n_free_ok;
            if (out_load)         r_ov <= 1'b1;
            else if (o_out.ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx <= n_chk_idx;
        r_slot    <= n_slot;
        r_free    <= n_free;
        if (o_pop)   r_evt <= i_evt;
        if (hit_now) r_ent <= rd;
        if (out_load) begin
            o_out.call_latency     <= r_evt.timestamp_ns - r_ent.start;
            o_out.out_call_id      <= r_ent.call;
            o_out.out_process_id   <= r_evt.process_id;
            o_out.out_thread_id    <= r_evt.thread_id;
            o_out.out_return_value <= r_evt.return_value;
            o_out.out_name_low     <= r_evt.name_low;
            o_out.out_name_high    <= r_evt.name_high;
        end
    end

    assign o_out.valid = r_ov;

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_pop)
        else $error("queue popped during table clear");

    a_result_from_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> ($past(r_state) == S_ACT))
        else $error("result loaded outside the action step");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_addr <= CNT_W'(TABLE_DEPTH))
        else $error("scan address ran past the table");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_out.ready) |=> r_ov)
        else $error("pending result lost");
endmodule
`default_nettype wire

[rtl/call_latency_matcher.sv]
// Channel   Dir  Handshake     Carries
// i_in      in   valid/ready   enter or exit event
// o_out     out  valid/ready   matched call latency record
// i_cfg_*   in   write enable  filter masks and target name
//
// Each queued event scans the table one entry a cycle, set by the single read
// port of the entry memory; a hit on entry k ends the scan early. Filtered
// enters are dropped at the input. After reset every table entry is cleared;
// no event is taken off the queue then. A two-entry queue and the output
// register let input and output stall independently.
`default_nettype none
module call_latency_matcher
    import clm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    clm_in_if.sink                    i_in,
    clm_out_if.source                 o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [63:0]          i_cfg_data
);
    logic push;
    t_evt push_evt;
    logic q_ready;
    logic q_valid;
    t_evt q_evt;
    logic pop;

    clm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_push     (push),
        .o_evt      (push_evt),
        .i_q_ready  (q_ready)
    );

    clm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_evt   (push_evt),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_evt   (q_evt),
        .i_pop   (pop)
    );

    clm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_evt     (q_evt),
        .o_pop     (pop),
        .o_out     (o_out)
    );
endmodule
`default_nettype wire
